// ----- hw/rtl/fpa_pkg.sv -----
// Shared widths, action codes and pipeline types for the fixed-point ALU.
// No dependencies; imported by fixed_point_alu_unit.
package fpa_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int WORD_WIDTH = 32;

    localparam int ACT_W  = 4;
    localparam int OPND_W = 32;
    localparam int RES_W  = 32;

    // headroom for a full 32x32 product and for a << FRAC_BITS
    localparam int VAL_W  = 66;
    localparam int DEN_W  = OPND_W;
    localparam int REM_W  = DEN_W + 1;
    localparam int QUO_W  = DEN_W + FRAC_BITS;

    // input capture, operate, QUO_W divider steps, divide finish, saturate
    localparam int NUM_STAGES = QUO_W + 4;

    localparam int S_TDATA_W = ((2 * OPND_W + 7) / 8) * 8;
    localparam int S_TUSER_W = ACT_W;
    localparam int M_TDATA_W = ((RES_W + 1 + 7) / 8) * 8;

    localparam logic [1:0] SKID_DEPTH = 2'd2;

    localparam logic signed [VAL_W-1:0] SAT_HI =
        signed'({{(VAL_W - WORD_WIDTH + 1){1'b0}}, {(WORD_WIDTH - 1){1'b1}}});
    localparam logic signed [VAL_W-1:0] SAT_LO = ~SAT_HI;

    localparam logic [VAL_W-1:0] RND_HALF = {{(VAL_W - 1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    localparam logic [ACT_W-1:0] ACT_ADD     = 4'd0;
    localparam logic [ACT_W-1:0] ACT_SUB     = 4'd1;
    localparam logic [ACT_W-1:0] ACT_MUL     = 4'd2;
    localparam logic [ACT_W-1:0] ACT_DIV     = 4'd3;
    localparam logic [ACT_W-1:0] ACT_GT      = 4'd4;
    localparam logic [ACT_W-1:0] ACT_LT      = 4'd5;
    localparam logic [ACT_W-1:0] ACT_GE      = 4'd6;
    localparam logic [ACT_W-1:0] ACT_LE      = 4'd7;
    localparam logic [ACT_W-1:0] ACT_EQ      = 4'd8;
    localparam logic [ACT_W-1:0] ACT_NE      = 4'd9;
    localparam logic [ACT_W-1:0] ACT_MIN     = 4'd10;
    localparam logic [ACT_W-1:0] ACT_MAX     = 4'd11;
    localparam logic [ACT_W-1:0] ACT_INC     = 4'd12;
    localparam logic [ACT_W-1:0] ACT_DEC     = 4'd13;
    localparam logic [ACT_W-1:0] ACT_TOINT   = 4'd14;
    localparam logic [ACT_W-1:0] ACT_FROMINT = 4'd15;

    typedef struct packed {
        logic [ACT_W-1:0]        act;
        logic [OPND_W-1:0]       opa;
        logic [OPND_W-1:0]       opb;
        logic [VAL_W-1:0]        val;
        logic                    cmp;
        logic [QUO_W-1:0]        quo;
        logic [REM_W-1:0]        rem;
        logic [DEN_W-1:0]        den;
        logic                    neg;
        logic                    zero;
    } pipe_t;

    typedef struct packed {
        logic [RES_W-1:0] result;
        logic             cmp;
    } out_t;

endpackage

// ----- hw/rtl/fixed_point_alu_unit.sv -----
// Fixed-point ALU top level: operate stage, pipelined restoring divider,
// rounding and saturation stages, two-entry output skid. Depends on fpa_pkg.

// Signed fixed-point ALU on raw words with FRAC_BITS fractional bits. One beat in
// on s_axis (action in tuser, operands in tdata) gives one beat out on m_axis.
// A new beat can be taken every cycle while the skid has room; words are Q24.8 by default.
// Pipeline depth is NUM_STAGES, set by the restoring divider, which resolves one quotient
// bit per pipeline stage. Every action travels the same pipeline, so results leave
// in order. A two-entry skid holds finished results; input is taken while it has room.
module fixed_point_alu_unit
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [31:0] operand_a, [63:32] operand_b
    input  logic [fpa_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [3:0] action
    input  logic [fpa_pkg::S_TUSER_W-1:0] s_axis_tuser,

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] result_value, [32] compare_true, rest zero
    output logic [fpa_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import fpa_pkg::*;

    pipe_t                  st_reg  [NUM_STAGES];
    pipe_t                  st_next [NUM_STAGES];
    logic [NUM_STAGES-1:0]  vld_reg;

    out_t                   skid0_reg, skid0_next;
    out_t                   skid1_reg, skid1_next;
    logic [1:0]             cnt_reg, cnt_next;

    logic                   adv;
    logic                   push;
    logic                   pop;
    out_t                   fin;

    // whole pipeline advances while the skid can still absorb one more beat
    assign adv           = (cnt_reg != SKID_DEPTH);
    assign s_axis_tready = adv;

    // input capture
    always_comb
    begin
        st_next[0]     = '0;
        st_next[0].act = s_axis_tuser[ACT_W-1:0];
        st_next[0].opa = s_axis_tdata[OPND_W-1:0];
        st_next[0].opb = s_axis_tdata[2*OPND_W-1:OPND_W];
    end

    // operate stage: simple actions, raw product, divider setup
    always_comb
    begin
        pipe_t                     s;
        pipe_t                     n;
        logic signed [OPND_W-1:0]  a_s;
        logic signed [OPND_W-1:0]  b_s;
        logic signed [VAL_W-1:0]   aw;
        logic signed [VAL_W-1:0]   bw;
        logic signed [2*OPND_W-1:0] prod;
        logic [OPND_W-1:0]         mag_a;
        logic [OPND_W-1:0]         mag_b;

        s     = st_reg[0];
        n     = s;
        a_s   = signed'(s.opa);
        b_s   = signed'(s.opb);
        aw    = signed'({{(VAL_W - OPND_W){s.opa[OPND_W-1]}}, s.opa});
        bw    = signed'({{(VAL_W - OPND_W){s.opb[OPND_W-1]}}, s.opb});
        prod  = a_s * b_s;
        mag_a = s.opa[OPND_W-1] ? (~s.opa + 1'b1) : s.opa;
        mag_b = s.opb[OPND_W-1] ? (~s.opb + 1'b1) : s.opb;

        n.val = '0;
        n.cmp = 1'b0;
        case (s.act)
            ACT_ADD:     n.val = aw + bw;
            ACT_SUB:     n.val = aw - bw;
            ACT_MUL:     n.val = {{(VAL_W - 2*OPND_W){prod[2*OPND_W-1]}}, prod};
            ACT_DIV:     n.val = '0;
            ACT_GT:      n.cmp = (a_s > b_s);
            ACT_LT:      n.cmp = (a_s < b_s);
            ACT_GE:      n.cmp = (a_s >= b_s);
            ACT_LE:      n.cmp = (a_s <= b_s);
            ACT_EQ:      n.cmp = (a_s == b_s);
            ACT_NE:      n.cmp = (a_s != b_s);
            ACT_MIN:     n.val = (a_s < b_s) ? aw : bw;
            ACT_MAX:     n.val = (a_s > b_s) ? aw : bw;
            ACT_INC:     n.val = aw + {{(VAL_W - 1){1'b0}}, 1'b1};
            ACT_DEC:     n.val = aw - {{(VAL_W - 1){1'b0}}, 1'b1};
            ACT_TOINT:   n.val = aw >>> FRAC_BITS;
            ACT_FROMINT: n.val = aw <<< FRAC_BITS;
            default:     n.val = '0;
        endcase

        n.quo  = {mag_a, {FRAC_BITS{1'b0}}};
        n.rem  = '0;
        n.den  = mag_b;
        n.neg  = s.opa[OPND_W-1] ^ s.opb[OPND_W-1];
        n.zero = (s.opa == '0) || (s.opb == '0);

        st_next[1] = n;
    end

    // divider: one quotient bit per stage; the first three stages also round the
    // product: magnitude, add half and shift, then restore the sign
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        always_comb
        begin
            pipe_t            s;
            pipe_t            n;
            logic [REM_W-1:0] rsh;

            s   = st_reg[k+1];
            n   = s;
            rsh = {s.rem[REM_W-2:0], s.quo[QUO_W-1]};
            if (rsh >= {1'b0, s.den})
            begin
                n.rem = rsh - {1'b0, s.den};
                n.quo = {s.quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                n.rem = rsh;
                n.quo = {s.quo[QUO_W-2:0], 1'b0};
            end

            // product sign matches the operand sign xor; a zero product stays zero
            if (s.act == ACT_MUL)
            begin
                if (k == 0)
                    n.val = s.val[VAL_W-1] ? (~s.val + 1'b1) : s.val;
                else if (k == 1)
                    n.val = (s.val + RND_HALF) >> FRAC_BITS;
                else if (k == 2)
                    n.val = s.neg ? (~s.val + 1'b1) : s.val;
            end

            st_next[k+2] = n;
        end
    end

    // divide finish: round half up on the remainder, sign folded into the same add
    // (-(q + r) = ~q + !r), zero operand gives 0
    always_comb
    begin
        pipe_t            s;
        pipe_t            n;
        logic             rnd;

        s   = st_reg[QUO_W+1];
        n   = s;
        rnd = ({s.rem, 1'b0} >= {2'b00, s.den});
        if (s.act == ACT_DIV)
        begin
            if (s.zero)
                n.val = '0;
            else if (s.neg)
                n.val = ~{{(VAL_W - QUO_W){1'b0}}, s.quo} + {{(VAL_W - 1){1'b0}}, ~rnd};
            else
                n.val = {{(VAL_W - QUO_W){1'b0}}, s.quo} + {{(VAL_W - 1){1'b0}}, rnd};
        end
        st_next[QUO_W+2] = n;
    end

    // saturate arithmetic results to the word range
    always_comb
    begin
        pipe_t                   s;
        pipe_t                   n;
        logic signed [VAL_W-1:0] sv;
        logic                    arith;

        s     = st_reg[QUO_W+2];
        n     = s;
        sv    = signed'(s.val);
        arith = (s.act == ACT_ADD) || (s.act == ACT_SUB) || (s.act == ACT_MUL) ||
                (s.act == ACT_DIV) || (s.act == ACT_INC) || (s.act == ACT_DEC) ||
                (s.act == ACT_FROMINT);
        if (arith && (sv > SAT_HI))
            n.val = SAT_HI;
        else if (arith && (sv < SAT_LO))
            n.val = SAT_LO;
        st_next[QUO_W+3] = n;
    end

    assign fin.result = st_reg[NUM_STAGES-1].val[RES_W-1:0];
    assign fin.cmp    = st_reg[NUM_STAGES-1].cmp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // output skid: two entries, head in skid0
    assign push = adv && vld_reg[NUM_STAGES-1];
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        skid0_next = skid0_reg;
        skid1_next = skid1_reg;
        cnt_next   = cnt_reg;
        case ({push, pop})
            2'b01:
            begin
                skid0_next = skid1_reg;
                cnt_next   = cnt_reg - 2'd1;
            end
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                    skid0_next = fin;
                else
                    skid1_next = fin;
                cnt_next = cnt_reg + 2'd1;
            end
            2'b11:
            begin
                // push only happens below full, so the head is the one leaving
                skid0_next = fin;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        skid0_reg <= skid0_next;
        skid1_reg <= skid1_next;
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {{(M_TDATA_W - RES_W - 1){1'b0}}, skid0_reg.cmp, skid0_reg.result};

endmodule
